FILE: src/lbce_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the line buffer cursor editor.
// Depends on nothing; every other file of the block imports it.
package lbce_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int IDX_W = $clog2(LINE_CAPACITY);
  localparam int CNT_W = $clog2(LINE_CAPACITY + 1);

  // Fixed field widths of the channels.
  localparam int OP_W  = 3;
  localparam int CH_W  = 8;
  localparam int IN_IDX_W = 6;
  localparam int LEN_W = 7;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_LEFT   = 3'd0;
  localparam logic [OP_W-1:0] OP_RIGHT  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CHANGE = 3'd4;
  localparam logic [OP_W-1:0] OP_READ   = 3'd5;

  localparam logic [ST_W-1:0] ST_DONE = 2'd0;
  localparam logic [ST_W-1:0] ST_EDGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(LINE_CAPACITY);

  // What every cell of the row does at a clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_SET
  } cell_kind_t;

  typedef struct packed {
    cell_kind_t        kind;
    logic [CH_W-1:0]   ch;
    logic [CNT_W-1:0]  cursor;
    logic [IDX_W-1:0]  rd_index;
  } cell_cmd_t;

endpackage

FILE: src/lbce_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command beats and result beats.
// Depends on lbce_pkg for field widths.
interface lbce_in_if;
  import lbce_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [CH_W-1:0]     ch;
  logic [IN_IDX_W-1:0] index;

  modport source (output valid, op, ch, index, input ready);
  modport sink (input valid, op, ch, index, output ready);
endinterface

interface lbce_out_if;
  import lbce_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] line_length;
  logic [LEN_W-1:0] cursor_pos;
  logic [CH_W-1:0]  read_byte;
  logic [ST_W-1:0]  status;

  modport source (output valid, line_length, cursor_pos, read_byte, status, input ready);
  modport sink (input valid, line_length, cursor_pos, read_byte, status, output ready);
endinterface

FILE: src/lbce_cell.sv
`timescale 1ns / 1ps
// One byte cell of the line row: shifts with its neighbors, loads a byte.
// Depends on lbce_pkg.
module lbce_cell
  import lbce_pkg::*;
(
  input  logic             clk,
  input  cell_cmd_t        cmd_i,
  input  logic [IDX_W-1:0] pos_i,
  input  logic [CH_W-1:0]  left_i,
  input  logic [CH_W-1:0]  right_i,
  output logic [CH_W-1:0]  byte_o,
  output logic [CH_W-1:0]  rd_o
);

  logic [CH_W-1:0]  byte_r;
  logic [CNT_W-1:0] pos_ext;

  assign pos_ext = CNT_W'(pos_i);
  assign byte_o  = byte_r;
  // Only the addressed cell puts its byte on the read bus.
  assign rd_o    = (pos_i == cmd_i.rd_index) ? byte_r : '0;

  always_ff @(posedge clk) begin
    unique case (cmd_i.kind)
      CELL_HOLD: ;
      CELL_INS: begin
        if (pos_ext > cmd_i.cursor) begin
          byte_r <= left_i;
        end else if (pos_ext == cmd_i.cursor) begin
          byte_r <= cmd_i.ch;
        end
      end
      CELL_DEL: begin
        if (pos_ext >= cmd_i.cursor) begin
          byte_r <= right_i;
        end
      end
      CELL_SET: begin
        if (pos_ext == cmd_i.cursor) begin
          byte_r <= cmd_i.ch;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: src/lbce_ctrl.sv
`timescale 1ns / 1ps
// Command decode, length and cursor registers, and the result register.
// Depends on lbce_pkg and the channel interfaces.
module lbce_ctrl
  import lbce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  lbce_in_if.sink           in_ch,
  lbce_out_if.source        out_ch,
  input  logic [CH_W-1:0]   rd_byte_i,
  output cell_cmd_t         cmd_o
);

  logic [CNT_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0] cursor_r, cursor_nxt;
  logic             out_valid_r;
  logic [LEN_W-1:0] len_out_r, len_out_nxt;
  logic [LEN_W-1:0] cur_out_r, cur_out_nxt;
  logic [CH_W-1:0]  rd_out_r, rd_out_nxt;
  logic [ST_W-1:0]  st_out_r, st_out_nxt;
  logic             accept;
  logic             full;
  logic             at_end;
  logic [CNT_W:0]   idx_ext;
  cell_kind_t       kind;

  // No beat is taken while reset is held.
  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (held_r >= CAP_CNT);
  assign at_end      = (cursor_r >= held_r);
  assign idx_ext     = (CNT_W + 1)'(in_ch.index);

  always_comb begin
    held_nxt   = held_r;
    cursor_nxt = cursor_r;
    st_out_nxt = ST_DONE;
    rd_out_nxt = '0;
    kind       = CELL_HOLD;
    unique case (in_ch.op)
      OP_LEFT: begin
        if (cursor_r != '0) begin
          cursor_nxt = cursor_r - 1'b1;
        end else begin
          st_out_nxt = ST_EDGE;
        end
      end
      OP_RIGHT: begin
        if (!at_end) begin
          cursor_nxt = cursor_r + 1'b1;
        end else begin
          st_out_nxt = ST_EDGE;
        end
      end
      OP_INSERT, OP_CHANGE: begin
        if (in_ch.op == OP_CHANGE && !at_end) begin
          kind = CELL_SET;
        end else if (full) begin
          st_out_nxt = ST_FULL;
        end else begin
          kind       = CELL_INS;
          held_nxt   = held_r + 1'b1;
          cursor_nxt = cursor_r + 1'b1;
        end
      end
      OP_ERASE: begin
        if (!at_end) begin
          kind     = CELL_DEL;
          held_nxt = held_r - 1'b1;
        end else begin
          st_out_nxt = ST_EDGE;
        end
      end
      OP_READ: begin
        if (idx_ext < (CNT_W + 1)'(held_r) &&
            idx_ext < (CNT_W + 1)'(LINE_CAPACITY)) begin
          rd_out_nxt = rd_byte_i;
        end else begin
          st_out_nxt = ST_EDGE;
        end
      end
      default: begin
        st_out_nxt = ST_EDGE;
      end
    endcase
    len_out_nxt = LEN_W'(held_nxt);
    cur_out_nxt = LEN_W'(cursor_nxt);
  end

  always_comb begin
    cmd_o.kind     = accept ? kind : CELL_HOLD;
    cmd_o.ch       = in_ch.ch;
    cmd_o.cursor   = cursor_r;
    cmd_o.rd_index = IDX_W'(in_ch.index);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        held_r      <= held_nxt;
        cursor_r    <= cursor_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      len_out_r <= len_out_nxt;
      cur_out_r <= cur_out_nxt;
      rd_out_r  <= rd_out_nxt;
      st_out_r  <= st_out_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.line_length = len_out_r;
  assign out_ch.cursor_pos  = cur_out_r;
  assign out_ch.read_byte   = rd_out_r;
  assign out_ch.status      = st_out_r;

`ifndef SYNTHESIS
  a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= held_r)
    else $error("cursor beyond line length");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CAP_CNT)
    else $error("line length beyond capacity");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && st_out_r == ST_FULL |-> len_out_r == LEN_W'(LINE_CAPACITY))
    else $error("full status with room left");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && kind == CELL_INS |=> held_r == $past(held_r) + 1'b1)
    else $error("insert did not grow the line");
`endif

endmodule

FILE: src/line_buffer_cursor_editor_unit.sv
`timescale 1ns / 1ps
// Top level of the line buffer cursor editor: control plus the row of byte cells.
// Depends on lbce_pkg, the channel interfaces, lbce_ctrl and lbce_cell.
//
// Usage: each beat on in_ch is one edit command (op, ch, index): left, right,
// insert, erase, change or read. Each command returns exactly one beat on
// out_ch with the line length and cursor after the command, the byte read
// (zero unless a read hits a held position) and a status: done, no effect at
// a boundary, or line full with the byte dropped.
// The line lives in a row of LINE_CAPACITY byte cells. An insert shifts every
// cell right of the cursor one place to the right; an erase
// shifts the tail one place left. A read picks the addressed cell off an OR
// bus that only that cell drives.
// An accepted command's result beat is registered and valid in the next cycle, and
// one command is taken every cycle while results are taken: the cell row shifts on
// the edge that accepts a command, and the next command enters in the same cycle
// that the waiting result is taken. When the receiver stalls, the result beat holds
// and in_ch.ready stays low until it is taken. Synchronous reset (rst_n low) empties
// the line, puts the cursor at zero and holds in_ch.ready low; cell contents are not
// cleared, since only cells below the length are ever read.
module line_buffer_cursor_editor_unit
  import lbce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lbce_in_if.sink     in_ch,
  lbce_out_if.source  out_ch
);

  cell_cmd_t       cmd;
  logic [CH_W-1:0] cell_byte [LINE_CAPACITY];
  logic [CH_W-1:0] cell_rd   [LINE_CAPACITY];
  logic [CH_W-1:0] rd_bus;

  lbce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .rd_byte_i (rd_bus),
    .cmd_o     (cmd)
  );

  // The row of cells. The first cell has no left neighbor and takes zero;
  // the last one refills itself from its own byte when the tail moves left.
  for (genvar i = 0; i < LINE_CAPACITY; i++) begin : g_cell
    logic [CH_W-1:0] left_b;
    logic [CH_W-1:0] right_b;

    if (i == 0) begin : g_first
      assign left_b = '0;
    end else begin : g_mid_l
      assign left_b = cell_byte[i-1];
    end

    if (i == LINE_CAPACITY - 1) begin : g_last
      assign right_b = cell_byte[i];
    end else begin : g_mid_r
      assign right_b = cell_byte[i+1];
    end

    lbce_cell u_cell (
      .clk     (clk),
      .cmd_i   (cmd),
      .pos_i   (IDX_W'(i)),
      .left_i  (left_b),
      .right_i (right_b),
      .byte_o  (cell_byte[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // Read bus: at most one cell drives a nonzero byte.
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < LINE_CAPACITY; k++) begin
      rd_bus = rd_bus | cell_rd[k];
    end
  end

endmodule
